// ----- rtl/core/srps_pkg.sv -----
// Shared types and constants for the servo recipe PWM sequencer.
// Holds the request and result structs, register indexes, opcodes and reset values.
// No dependencies.
package srps_pkg;

  localparam int RECIPE_DEPTH_DEF = 32;

  localparam int PER_W    = 20;
  localparam int OFS_W    = 16;
  localparam int STEP_W   = 15;
  localparam int UNIT_W   = 19;
  localparam int SETTLE_W = 19;
  localparam int WAIT_W   = 24;
  localparam int POS_W    = 5;
  localparam int BYTE_W   = 8;
  localparam int ARG_W    = 5;
  localparam int ROP_W    = 3;
  localparam int RIDX_W   = 6;
  localparam int WADDR_W  = 5;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int REGSEL_W = 3;

  // request opcodes
  localparam logic [1:0] ITEM_WRITE   = 2'd0;
  localparam logic [1:0] ITEM_TICK    = 2'd1;
  localparam logic [1:0] ITEM_RESTART = 2'd2;

  // recipe byte opcodes (top three bits)
  localparam logic [ROP_W-1:0] OP_HALT       = 3'd0;
  localparam logic [ROP_W-1:0] OP_MOV        = 3'd1;
  localparam logic [ROP_W-1:0] OP_WAIT       = 3'd2;
  localparam logic [ROP_W-1:0] OP_LOOP_START = 3'd4;
  localparam logic [ROP_W-1:0] OP_END_LOOP   = 3'd5;

  // register indexes
  localparam logic [REGSEL_W-1:0] REG_PERIOD = 3'd0;
  localparam logic [REGSEL_W-1:0] REG_OFFSET = 3'd1;
  localparam logic [REGSEL_W-1:0] REG_STEP   = 3'd2;
  localparam logic [REGSEL_W-1:0] REG_UNIT   = 3'd3;
  localparam logic [REGSEL_W-1:0] REG_SETTLE = 3'd4;

  localparam logic [PER_W-1:0]    PERIOD_RST = 20'd20000;
  localparam logic [OFS_W-1:0]    OFFSET_RST = 16'd388;
  localparam logic [STEP_W-1:0]   STEP_RST   = 15'd400;
  localparam logic [UNIT_W-1:0]   UNIT_RST   = 19'd100000;
  localparam logic [SETTLE_W-1:0] SETTLE_RST = 19'd200000;
  localparam logic [PER_W-1:0]    PW_MAX     = 20'hFFFFF;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [WADDR_W-1:0] write_address;
    logic [BYTE_W-1:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic              pwm_level;
    logic [POS_W-1:0]  position;
    logic [RIDX_W-1:0] recipe_index;
    logic [ARG_W-1:0]  loop_remaining;
    logic              halted;
    logic              waiting;
  } out_item_t;

endpackage

// ----- rtl/core/servo_recipe_pwm_sequencer.sv -----
// Servo recipe sequencer with PWM generation; top level and only module.
// Recipe bytes sit in an internal synchronous memory; uses srps_pkg.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+----------------------------------
//   in_      | in  | in_valid / in_ready  | srps_pkg::in_item_t  (write/tick/restart)
//   out_     | out | out_valid / out_ready| srps_pkg::out_item_t (state after request)
//   config   | in  | psel/penable/pwrite  | paddr, pwdata, prdata (5 regs at 4*i)
//
// One request per cycle while in_ready is high. State updates at the accepting edge;
// the result is built from the updated state and lands in the output register once
// that register is free. The recipe memory is read every cycle at the next cursor
// (registered read, write data forwarded), so the byte at the cursor is always ready
// for a tick. Reset clears the per-entry valid bits directly; no clearing pass.
// With the output stalled, one request more is taken, then in_ready drops.
module servo_recipe_pwm_sequencer #(
  parameter int RECIPE_DEPTH = srps_pkg::RECIPE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  srps_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output srps_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srps_pkg::CFG_AW-1:0]   paddr,
  input  logic [srps_pkg::CFG_DW-1:0]   pwdata,
  output logic [srps_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int IDX_W = $clog2(RECIPE_DEPTH);
  localparam int CUR_W = $clog2(RECIPE_DEPTH + 1);
  localparam int PW    = srps_pkg::PER_W;
  localparam int WW    = srps_pkg::WAIT_W;
  localparam int AW    = srps_pkg::ARG_W;
  localparam int BW    = srps_pkg::BYTE_W;

  // configuration registers
  logic [PW-1:0]                   period_r;
  logic [srps_pkg::OFS_W-1:0]      offset_r;
  logic [srps_pkg::STEP_W-1:0]     step_r;
  logic [srps_pkg::UNIT_W-1:0]     unit_r;
  logic [srps_pkg::SETTLE_W-1:0]   settle_r;
  logic                            cfg_we;
  logic [srps_pkg::REGSEL_W-1:0]   reg_sel;

  // sequencer and pwm state
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [AW-1:0]     loop_cnt_r, loop_cnt_nxt;
  logic [IDX_W-1:0]  loop_head_r, loop_head_nxt;
  logic [WW-1:0]     wait_r, wait_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     pw_r, pw_nxt;
  logic [PW-1:0]     cnt_r, cnt_nxt;

  // recipe memory and read side
  logic [BW-1:0]           mem [RECIPE_DEPTH];
  logic [RECIPE_DEPTH-1:0] vld_r;
  logic [BW-1:0]           mem_q_r;
  logic                    vld_q_r;
  logic                    fwd_r;
  logic [BW-1:0]           fwd_byte_r;
  logic                    in_range_r;
  logic [IDX_W-1:0]        raddr;
  logic [IDX_W-1:0]        waddr;
  logic [IDX_W+4:0]        waddr_ext;
  logic                    waddr_ok;
  logic                    mem_we;

  // handshake
  logic                    res_pend_r;
  logic                    out_valid_r;
  srps_pkg::out_item_t     out_r;
  logic                    load_out;

  logic                    acc, is_write, is_tick, is_restart;
  logic [BW-1:0]           cur_byte;
  logic [srps_pkg::ROP_W-1:0] cur_op;
  logic [AW-1:0]           cur_arg;
  logic                    halted;
  logic [AW-1:0]           travel;
  logic [AW:0]             arg_p1;
  logic [WW-1:0]           settle_prod;
  logic [WW-1:0]           unit_prod;
  logic [PW-1:0]           eff_per;
  logic [PW:0]             cnt_inc;
  logic [PW-1:0]           step_prod;
  logic [PW:0]             pw_sum;
  logic [CUR_W+5:0]        cur_ext;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = paddr[srps_pkg::CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= srps_pkg::PERIOD_RST;
      offset_r <= srps_pkg::OFFSET_RST;
      step_r   <= srps_pkg::STEP_RST;
      unit_r   <= srps_pkg::UNIT_RST;
      settle_r <= srps_pkg::SETTLE_RST;
    end else if (cfg_we) begin
      case (reg_sel)
        srps_pkg::REG_PERIOD: period_r <= pwdata[PW-1:0];
        srps_pkg::REG_OFFSET: offset_r <= pwdata[srps_pkg::OFS_W-1:0];
        srps_pkg::REG_STEP:   step_r   <= pwdata[srps_pkg::STEP_W-1:0];
        srps_pkg::REG_UNIT:   unit_r   <= pwdata[srps_pkg::UNIT_W-1:0];
        srps_pkg::REG_SETTLE: settle_r <= pwdata[srps_pkg::SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      srps_pkg::REG_PERIOD: prdata = {12'd0, period_r};
      srps_pkg::REG_OFFSET: prdata = {16'd0, offset_r};
      srps_pkg::REG_STEP:   prdata = {17'd0, step_r};
      srps_pkg::REG_UNIT:   prdata = {13'd0, unit_r};
      srps_pkg::REG_SETTLE: prdata = {13'd0, settle_r};
      default:              prdata = '0;
    endcase
  end

  // ---------------- request decode ----------------
  assign load_out   = res_pend_r && (!out_valid_r || out_ready);
  assign in_ready   = !res_pend_r || !out_valid_r || out_ready;
  assign acc        = in_valid && in_ready;
  assign is_write   = acc && (in_data.opcode == srps_pkg::ITEM_WRITE);
  assign is_tick    = acc && (in_data.opcode == srps_pkg::ITEM_TICK);
  assign is_restart = acc && (in_data.opcode == srps_pkg::ITEM_RESTART);

  // byte at the cursor; past the end reads as the end marker
  always_comb begin
    if (!in_range_r) begin
      cur_byte = '0;
    end else if (fwd_r) begin
      cur_byte = fwd_byte_r;
    end else if (vld_q_r) begin
      cur_byte = mem_q_r;
    end else begin
      cur_byte = '0;
    end
  end

  assign cur_op  = cur_byte[BW-1:AW];
  assign cur_arg = cur_byte[AW-1:0];
  assign halted  = (cur_op == srps_pkg::OP_HALT);

  assign travel      = (cur_arg > pos_r) ? (cur_arg - pos_r) : (pos_r - cur_arg);
  assign arg_p1      = {1'b0, cur_arg} + (AW+1)'(1);
  assign settle_prod = {5'd0, settle_r} * {19'd0, travel};
  assign unit_prod   = {5'd0, unit_r} * {18'd0, arg_p1};

  assign eff_per   = (period_r == '0) ? PW'(1) : period_r;
  assign cnt_inc   = {1'b0, cnt_r} + (PW+1)'(1);
  // pulse latched from the position after this tick's instruction
  assign step_prod = {5'd0, step_r} * {15'd0, pos_nxt};
  assign pw_sum    = {5'd0, offset_r} + {1'b0, step_prod};

  always_comb begin
    cursor_nxt    = cursor_r;
    loop_cnt_nxt  = loop_cnt_r;
    loop_head_nxt = loop_head_r;
    wait_nxt      = wait_r;
    pos_nxt       = pos_r;
    pw_nxt        = pw_r;
    cnt_nxt       = cnt_r;
    if (is_restart) begin
      cursor_nxt    = '0;
      loop_cnt_nxt  = '0;
      loop_head_nxt = '0;
      wait_nxt      = '0;
    end
    if (is_tick) begin
      if (wait_r != '0) begin
        wait_nxt = wait_r - WW'(1);
      end else if (!halted) begin
        cursor_nxt = cursor_r + CUR_W'(1);
        case (cur_op)
          srps_pkg::OP_MOV: begin
            pos_nxt  = cur_arg;
            wait_nxt = settle_prod;
          end
          srps_pkg::OP_WAIT: begin
            wait_nxt = unit_prod;
          end
          srps_pkg::OP_LOOP_START: begin
            if (loop_cnt_r == '0) begin
              loop_cnt_nxt = cur_arg;
            end
            loop_head_nxt = cursor_r[IDX_W-1:0];
          end
          srps_pkg::OP_END_LOOP: begin
            if (loop_cnt_r != '0) begin
              loop_cnt_nxt = loop_cnt_r - AW'(1);
              cursor_nxt   = CUR_W'({1'b0, loop_head_r} + (IDX_W+1)'(1));
            end
          end
          default: ;
        endcase
      end
      if (cnt_inc >= {1'b0, eff_per}) begin
        cnt_nxt = '0;
        pw_nxt  = pw_sum[PW] ? srps_pkg::PW_MAX : pw_sum[PW-1:0];
      end else begin
        cnt_nxt = cnt_inc[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      loop_cnt_r  <= '0;
      loop_head_r <= '0;
      wait_r      <= '0;
      pos_r       <= '0;
      pw_r        <= PW'(srps_pkg::OFFSET_RST);
      cnt_r       <= '0;
    end else begin
      cursor_r    <= cursor_nxt;
      loop_cnt_r  <= loop_cnt_nxt;
      loop_head_r <= loop_head_nxt;
      wait_r      <= wait_nxt;
      pos_r       <= pos_nxt;
      pw_r        <= pw_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // ---------------- recipe memory ----------------
  assign waddr_ext = {{IDX_W{1'b0}}, in_data.write_address};
  assign waddr_ok  = (waddr_ext < (IDX_W+5)'(RECIPE_DEPTH));
  assign waddr     = waddr_ext[IDX_W-1:0];
  assign mem_we    = is_write && waddr_ok;
  assign raddr     = cursor_nxt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= in_data.write_byte;
    end
    mem_q_r    <= mem[raddr];
    fwd_byte_r <= in_data.write_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      vld_q_r    <= 1'b0;
      fwd_r      <= 1'b0;
      in_range_r <= 1'b1;
    end else begin
      if (mem_we) begin
        vld_r[waddr] <= 1'b1;
      end
      vld_q_r    <= vld_r[raddr];
      // same-cycle write to the entry being read
      fwd_r      <= mem_we && (waddr == raddr);
      in_range_r <= (cursor_nxt < CUR_W'(RECIPE_DEPTH));
    end
  end

  // ---------------- result register ----------------
  assign cur_ext = {6'd0, cursor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        res_pend_r <= 1'b1;
      end else if (load_out) begin
        res_pend_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.pwm_level      <= (cnt_r < pw_r) || (pw_r >= eff_per);
      out_r.position       <= pos_r;
      out_r.recipe_index   <= cur_ext[srps_pkg::RIDX_W-1:0];
      out_r.loop_remaining <= loop_cnt_r;
      out_r.halted         <= halted;
      out_r.waiting        <= (wait_r != '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- checks ----------------
  a_cursor_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CUR_W'(RECIPE_DEPTH))
    else $error("cursor beyond recipe end");

  a_stall_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    (res_pend_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("request taken while result path is full");

  a_wait_holds_cursor : assert property (@(posedge clk) disable iff (!rst_n)
    (is_tick && wait_r != '0) |=> ($stable(cursor_r) && $stable(loop_cnt_r)))
    else $error("sequencer advanced during a delay");

  a_restart_clears : assert property (@(posedge clk) disable iff (!rst_n)
    is_restart |=> (cursor_r == '0 && wait_r == '0 && loop_cnt_r == '0))
    else $error("restart left sequencer state behind");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for servo_recipe_pwm_sequencer: recipe, tick and restart requests
// go in under random idling, and each status result is checked against an in-bench predictor.
// Depends on rtl/core/srps_pkg.sv and rtl/core/servo_recipe_pwm_sequencer.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ITEM_SPARE = 2'd3;
  localparam logic [srps_pkg::ROP_W-1:0] OP_SPARE_A = 3'd3;
  localparam logic [srps_pkg::ROP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [srps_pkg::ROP_W-1:0] OP_SPARE_C = 3'd7;
  localparam int DEPTH = srps_pkg::RECIPE_DEPTH_DEF;
  localparam int SWAP_AT = 380;
  localparam int CALM_AT = 760;
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 140;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  srps_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  srps_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [srps_pkg::CFG_AW-1:0] paddr = '0;
  logic [srps_pkg::CFG_DW-1:0] pwdata = '0;
  logic [srps_pkg::CFG_DW-1:0] prdata;
  logic pready;

  servo_recipe_pwm_sequencer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and its copy of the registers
  logic [7:0]  recipe_mem [DEPTH];
  logic [31:0] cur_idx = 0;
  logic [31:0] loops_left = 0;
  logic [31:0] loop_head = 0;
  logic [31:0] wait_left = 0;
  logic [31:0] cur_pos = 0;
  logic [31:0] pulse_w = 32'(srps_pkg::OFFSET_RST);
  logic [31:0] pwm_cnt = 0;
  logic [31:0] cfg_period = 32'(srps_pkg::PERIOD_RST);
  logic [31:0] cfg_offset = 32'(srps_pkg::OFFSET_RST);
  logic [31:0] cfg_step = 32'(srps_pkg::STEP_RST);
  logic [31:0] cfg_unit = 32'(srps_pkg::UNIT_RST);
  logic [31:0] cfg_settle = 32'(srps_pkg::SETTLE_RST);

  srps_pkg::in_item_t  request_q[$];
  srps_pkg::out_item_t expected_status_q[$];
  int queued_cnt = 0;
  int accepted_cnt = 0;
  int tick_cnt = 0;
  int checked_cnt = 0;
  int mismatch_cnt = 0;
  int recipe_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic bit seq_halted();
    if (cur_idx >= DEPTH) return 1'b1;
    return recipe_mem[cur_idx[4:0]][7:5] == srps_pkg::OP_HALT;
  endfunction

  function automatic srps_pkg::out_item_t advance_sequencer(srps_pkg::in_item_t req);
    srps_pkg::out_item_t st;
    logic [7:0] instr;
    logic [31:0] arg, span, pw, per;
    per = (cfg_period == 0) ? 32'd1 : cfg_period;
    case (req.opcode)
      srps_pkg::ITEM_WRITE: recipe_mem[req.write_address] = req.write_byte;
      srps_pkg::ITEM_TICK: begin
        if (wait_left != 0) begin
          wait_left = wait_left - 1;
        end else if (!seq_halted()) begin
          instr = recipe_mem[cur_idx[4:0]];
          arg = 32'(instr[4:0]);
          case (instr[7:5])
            srps_pkg::OP_MOV: begin
              span = (arg > cur_pos) ? arg - cur_pos : cur_pos - arg;
              cur_pos = arg;
              wait_left = cfg_settle * span;
            end
            srps_pkg::OP_WAIT: wait_left = cfg_unit * (arg + 1);
            srps_pkg::OP_LOOP_START: begin
              if (loops_left == 0) loops_left = arg;
              loop_head = cur_idx;
            end
            srps_pkg::OP_END_LOOP: begin
              if (loops_left != 0) begin
                loops_left = loops_left - 1;
                cur_idx = loop_head;
              end
            end
            default: ;
          endcase
          cur_idx = cur_idx + 1;
        end
        pwm_cnt = pwm_cnt + 1;
        // new frame: pulse width follows the position as it stands now
        if (pwm_cnt >= per) begin
          pwm_cnt = 0;
          pw = cfg_offset + cfg_step * cur_pos;
          pulse_w = (pw > 32'(srps_pkg::PW_MAX)) ? 32'(srps_pkg::PW_MAX) : pw;
        end
      end
      srps_pkg::ITEM_RESTART: begin
        cur_idx = 0;
        loops_left = 0;
        loop_head = 0;
        wait_left = 0;
      end
      default: ;
    endcase
    st.pwm_level      = (pwm_cnt < pulse_w) || (pulse_w >= per);
    st.position       = cur_pos[4:0];
    st.recipe_index   = cur_idx[5:0];
    st.loop_remaining = loops_left[4:0];
    st.halted         = seq_halted();
    st.waiting        = wait_left != 0;
    return st;
  endfunction

  function automatic bit idle_roll(bit sender_side);
    int pct;
    if (accepted_cnt < SWAP_AT) pct = sender_side ? 30 : 54;
    else if (accepted_cnt < CALM_AT) pct = sender_side ? 54 : 30;
    else pct = 0;
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    if (mismatch_cnt < 40)
      $display("mismatch at result %0d, %s: got %0d expected %0d", checked_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_status(srps_pkg::out_item_t got, srps_pkg::out_item_t want);
    if (got.pwm_level !== want.pwm_level)
      flag_mismatch("pwm_level", int'(got.pwm_level), int'(want.pwm_level));
    if (got.position !== want.position)
      flag_mismatch("position", int'(got.position), int'(want.position));
    if (got.recipe_index !== want.recipe_index)
      flag_mismatch("recipe_index", int'(got.recipe_index), int'(want.recipe_index));
    if (got.loop_remaining !== want.loop_remaining)
      flag_mismatch("loop_remaining", int'(got.loop_remaining), int'(want.loop_remaining));
    if (got.halted !== want.halted)
      flag_mismatch("halted", int'(got.halted), int'(want.halted));
    if (got.waiting !== want.waiting)
      flag_mismatch("waiting", int'(got.waiting), int'(want.waiting));
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_status_q.push_back(advance_sequencer(in_data));
        accepted_cnt++;
        if (in_data.opcode == srps_pkg::ITEM_TICK) tick_cnt++;
      end
      if (!in_valid || in_ready) begin
        // no gaps while the receiver is held off, so the block backs up
        if (request_q.size() != 0 && (hold_left != 0 || !idle_roll(1'b1))) begin
          in_data <= request_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status_q.size() == 0) flag_mismatch("unexpected result", 0, 0);
        else check_status(out_data, expected_status_q.pop_front());
        checked_cnt++;
      end
      if (!hold_done && accepted_cnt >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_roll(1'b0);
      end
    end
  end

  task automatic queue_request(logic [1:0] op, logic [4:0] addr, logic [7:0] data);
    srps_pkg::in_item_t r;
    r.opcode = op;
    r.write_address = addr;
    r.write_byte = data;
    request_q.push_back(r);
    queued_cnt++;
  endtask

  task automatic write_reg(logic [srps_pkg::REGSEL_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      srps_pkg::REG_PERIOD: cfg_period = 32'(val[srps_pkg::PER_W-1:0]);
      srps_pkg::REG_OFFSET: cfg_offset = 32'(val[srps_pkg::OFS_W-1:0]);
      srps_pkg::REG_STEP:   cfg_step = 32'(val[srps_pkg::STEP_W-1:0]);
      srps_pkg::REG_UNIT:   cfg_unit = 32'(val[srps_pkg::UNIT_W-1:0]);
      srps_pkg::REG_SETTLE: cfg_settle = 32'(val[srps_pkg::SETTLE_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || expected_status_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] random_instr(bit no_halt);
    int pick;
    logic [4:0] arg, short_arg;
    pick = $urandom_range(0, 11);
    arg = 5'($urandom_range(0, 31));
    short_arg = 5'($urandom_range(0, 2));
    case (pick)
      0, 1, 2: return {srps_pkg::OP_MOV, arg};
      3, 4:    return {srps_pkg::OP_WAIT, ($urandom_range(0, 3) == 0) ? arg : short_arg};
      5:       return {srps_pkg::OP_LOOP_START,
                       ($urandom_range(0, 4) == 0) ? arg : short_arg};
      6, 7:    return {srps_pkg::OP_END_LOOP, arg};
      8:       return {OP_SPARE_A, arg};
      9:       return {OP_SPARE_B, arg};
      10:      return {OP_SPARE_C, arg};
      default: return no_halt ? {OP_SPARE_A, arg} : {srps_pkg::OP_HALT, arg};
    endcase
  endfunction

  // one recipe: load it, restart, then tick through it with some noise mixed in
  task automatic queue_recipe();
    int len, ticks;
    logic [5:0] a;
    bit fill_all;
    fill_all = ($urandom_range(0, 7) == 0);
    len = fill_all ? DEPTH : $urandom_range(1, 10);
    for (a = '0; a < len; a++)
      queue_request(srps_pkg::ITEM_WRITE, a[4:0], random_instr(fill_all));
    // a full memory with no end marker runs off the end
    if (!fill_all)
      queue_request(srps_pkg::ITEM_WRITE, a[4:0],
                    {srps_pkg::OP_HALT, 5'($urandom_range(0, 31))});
    queue_request(srps_pkg::ITEM_RESTART, 5'($urandom_range(0, 31)),
                  8'($urandom_range(0, 255)));
    ticks = fill_all ? $urandom_range(80, 120) : $urandom_range(25, 70);
    repeat (ticks) begin
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0, 1: queue_request(srps_pkg::ITEM_WRITE, 5'($urandom_range(0, 31)),
                              8'($urandom_range(0, 255)));
          2: queue_request(ITEM_SPARE, 5'($urandom_range(0, 31)),
                           8'($urandom_range(0, 255)));
          default: queue_request(srps_pkg::ITEM_RESTART, 5'($urandom_range(0, 31)),
                                 8'($urandom_range(0, 255)));
        endcase
      end
      queue_request(srps_pkg::ITEM_TICK, 5'($urandom_range(0, 31)),
                    8'($urandom_range(0, 255)));
    end
    recipe_cnt++;
  endtask

  initial begin
    int ph, target;
    logic [31:0] v_per, v_ofs, v_step, v_unit, v_settle;
    for (int i = 0; i < DEPTH; i++) recipe_mem[5'(i)] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: empty memory halts, end marker with argument still halts
    queue_request(srps_pkg::ITEM_TICK, 5'h00, 8'h00);
    queue_request(srps_pkg::ITEM_TICK, 5'h1F, 8'hFF);
    queue_request(ITEM_SPARE, 5'h15, 8'hA5);
    queue_request(srps_pkg::ITEM_WRITE, 5'h1F, 8'hFF);
    queue_request(srps_pkg::ITEM_WRITE, 5'h00, {srps_pkg::OP_HALT, 5'h1F});
    queue_request(srps_pkg::ITEM_TICK, 5'h0A, 8'h5A);
    queue_request(srps_pkg::ITEM_RESTART, 5'h00, 8'h00);
    wait_drained();

    // short delays so a whole loop fits in a few ticks
    write_reg(srps_pkg::REG_PERIOD, 5);
    write_reg(srps_pkg::REG_OFFSET, 1);
    write_reg(srps_pkg::REG_STEP, 1);
    write_reg(srps_pkg::REG_UNIT, 1);
    write_reg(srps_pkg::REG_SETTLE, 1);
    queue_request(srps_pkg::ITEM_WRITE, 5'd0, {srps_pkg::OP_MOV, 5'd2});
    queue_request(srps_pkg::ITEM_WRITE, 5'd1, {srps_pkg::OP_LOOP_START, 5'd1});
    queue_request(srps_pkg::ITEM_WRITE, 5'd2, {srps_pkg::OP_WAIT, 5'd0});
    queue_request(srps_pkg::ITEM_WRITE, 5'd3, {OP_SPARE_B, 5'd5});
    queue_request(srps_pkg::ITEM_WRITE, 5'd4, {srps_pkg::OP_END_LOOP, 5'd0});
    queue_request(srps_pkg::ITEM_WRITE, 5'd5, {srps_pkg::OP_MOV, 5'd0});
    repeat (16) queue_request(srps_pkg::ITEM_TICK, 5'd0, 8'd0);
    wait_drained();

    target = queued_cnt;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        1: begin  // all registers at their top
          v_per = 32'hFFFFF; v_ofs = 32'hFFFF; v_step = 32'h7FFF;
          v_unit = 32'h7FFFF; v_settle = 32'h7FFFF;
        end
        2: begin  // period now far below the counter, pulse wider than the frame
          v_per = 3; v_ofs = 32'hFFFF; v_step = 0; v_unit = 1; v_settle = 1;
        end
        3: begin  // zero period behaves as one
          v_per = 0; v_ofs = 1; v_step = 1; v_unit = 2; v_settle = 1;
        end
        4: begin
          v_per = 1; v_ofs = 0; v_step = 0; v_unit = 1; v_settle = 0;
        end
        default: begin
          v_per = $urandom_range(1, 64);
          v_ofs = $urandom_range(0, 16);
          v_step = $urandom_range(0, 4);
          v_unit = $urandom_range(1, 4);
          v_settle = $urandom_range(0, 3);
        end
      endcase
      write_reg(srps_pkg::REG_PERIOD, v_per);
      write_reg(srps_pkg::REG_OFFSET, v_ofs);
      write_reg(srps_pkg::REG_STEP, v_step);
      write_reg(srps_pkg::REG_UNIT, v_unit);
      write_reg(srps_pkg::REG_SETTLE, v_settle);
      target += PHASE_ITEMS;
      while (queued_cnt < target) queue_recipe();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("ran %0d requests (%0d ticks, %0d random recipes) over 10 register settings,",
             accepted_cnt, tick_cnt, recipe_cnt);
    $display("checked %0d results with %0d mismatches", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("servo_recipe_pwm_sequencer test passed");
    end else begin
      $display("servo_recipe_pwm_sequencer test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("servo_recipe_pwm_sequencer test failed");
    $finish;
  end

endmodule
